// ===== rtl/adsr_pkg.sv =====
// ============================================================================
// adsr_pkg
// Shared types and constants for the linear ADSR envelope generator.
// ============================================================================
`default_nettype none

package adsr_pkg;

    // Field and datapath widths
    localparam int TIME_BITS  = 32;
    localparam int LEVEL_BITS = 16;
    localparam int DUR_BITS   = 24;
    localparam int PROD_BITS  = LEVEL_BITS + DUR_BITS;
    localparam int CNT_BITS   = $clog2(LEVEL_BITS + 1);
    localparam int CFG_IDX_BITS = 3;

    // Levels below 0.0001 of full scale read as silence
    localparam logic [LEVEL_BITS-1:0] EPS_LIMIT =
        LEVEL_BITS'((2 ** LEVEL_BITS + 9999) / 10000);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD    = 3'd4;

    // Register reset values
    localparam logic [DUR_BITS-1:0]   RST_ATTACK  = 24'd4410;
    localparam logic [DUR_BITS-1:0]   RST_DECAY   = 24'd441;
    localparam logic [DUR_BITS-1:0]   RST_RELEASE = 24'd8820;
    localparam logic [LEVEL_BITS-1:0] RST_PEAK    = 16'd65535;
    localparam logic [LEVEL_BITS-1:0] RST_HOLD    = 16'd52428;

    // Action codes
    localparam logic [1:0] ACT_QUERY    = 2'd0;
    localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd2;

    // Phase codes
    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_SUSTAIN = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [TIME_BITS-1:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [1:0]            phase;
    } t_out_item;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/adsr_divider.sv =====
// ============================================================================
// adsr_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in LEVEL_BITS, so the upper numerator bits seed the partial remainder.
// ============================================================================
`default_nettype none

module adsr_divider (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire  [adsr_pkg::PROD_BITS-1:0]        i_num,
    input  wire  [adsr_pkg::DUR_BITS-1:0]         i_den,
    output adsr_pkg::t_div_stat                   o_stat,
    output logic [adsr_pkg::LEVEL_BITS-1:0]       o_quot
);

    localparam int LB = adsr_pkg::LEVEL_BITS;
    localparam int DB = adsr_pkg::DUR_BITS;
    localparam int CB = adsr_pkg::CNT_BITS;

    logic [DB-1:0] r_rem;
    logic [LB-1:0] r_lo;
    logic [LB-1:0] r_quot;
    logic [CB-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DB:0]   trial;
    logic [DB-1:0] diff;
    logic          fits;
    logic [DB-1:0] n_rem;

    // One shift-subtract step; the low bits of the difference are exact when it fits
    always_comb begin
        trial = {r_rem, r_lo[LB-1]};
        diff  = trial[DB-1:0] - i_den;
        fits  = (trial >= {1'b0, i_den});
        n_rem = fits ? diff : trial[DB-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(LB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[adsr_pkg::PROD_BITS-1:LB];
            r_lo  <= i_num[LB-1:0];
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_lo   <= {r_lo[LB-2:0], 1'b0};
            r_quot <= {r_quot[LB-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// ===== rtl/adsr_envelope_generator_core.sv =====
// ============================================================================
// adsr_envelope_generator_core
// Linear ADSR envelope: latches note on/off times, picks the phase from the
// elapsed time and scales the ramp with one multiply and a serial divide.
// ============================================================================
// Sequencing: a ramp phase passes S_DIFF, S_SEL, S_MUL, S_DIV and S_FIN
//   (one multiply, then the serial divide); sustain or silent release skips S_MUL and S_DIV.
// Throughput: the core takes no new item until the last one has left S_FIN;
//   the input is held off while an item works, and a finished item waits in
//   S_FIN until the output register is free to take its result.
// Reset: synchronous active low; note state cleared (gate released), the
//   registers return to their defaults, no result pending.
`default_nettype none

module adsr_envelope_generator_core (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // input channel
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  adsr_pkg::t_in_item                     i_in_data,
    // output channel
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output adsr_pkg::t_out_item                    o_out_data,
    // configuration
    input  wire                                    i_cfg_we,
    input  wire  [adsr_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire  [adsr_pkg::DUR_BITS-1:0]          i_cfg_data
);

    localparam int TB = adsr_pkg::TIME_BITS;
    localparam int LB = adsr_pkg::LEVEL_BITS;
    localparam int DB = adsr_pkg::DUR_BITS;
    localparam int PB = adsr_pkg::PROD_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIFF = 6'b000010,
        S_SEL  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // How the final level is formed
    typedef enum logic [1:0] {
        M_DIRECT = 2'd0,
        M_QUOT   = 2'd1,
        M_ADD    = 2'd2,
        M_SUB    = 2'd3
    } t_mode;

    // Configuration registers
    logic [DB-1:0] r_attack, r_decay, r_release;
    logic [LB-1:0] r_peak, r_hold;

    // Note state
    logic [TB-1:0] r_start_time, r_stop_time;
    logic          r_gate;

    // Sequencer and working registers
    t_state        r_state, n_state;
    logic [TB-1:0] r_now;
    logic [TB-1:0] r_elapsed;
    t_mode         r_mode;
    logic [1:0]    r_phase;
    logic [LB-1:0] r_base;
    logic [LB-1:0] r_mul_a;
    logic [DB-1:0] r_mul_b;
    logic [DB-1:0] r_den;
    logic [PB-1:0] r_prod;
    logic          r_div_go;

    // Output register
    logic          r_out_valid;
    adsr_pkg::t_out_item r_out;

    adsr_pkg::t_div_stat div_stat;
    logic [LB-1:0] div_quot;

    logic          in_xfer;
    logic          out_free;

    // Phase selection results
    t_mode         sel_mode;
    logic [1:0]    sel_phase;
    logic [LB-1:0] sel_base, sel_a;
    logic [DB-1:0] sel_b, sel_den;
    logic [TB-1:0] decay_pos;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= adsr_pkg::RST_ATTACK;
            r_decay   <= adsr_pkg::RST_DECAY;
            r_release <= adsr_pkg::RST_RELEASE;
            r_peak    <= adsr_pkg::RST_PEAK;
            r_hold    <= adsr_pkg::RST_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                adsr_pkg::CFG_ATTACK:  r_attack  <= i_cfg_data;
                adsr_pkg::CFG_DECAY:   r_decay   <= i_cfg_data;
                adsr_pkg::CFG_RELEASE: r_release <= i_cfg_data;
                adsr_pkg::CFG_PEAK:    r_peak    <= i_cfg_data[LB-1:0];
                adsr_pkg::CFG_HOLD:    r_hold    <= i_cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    // Note on/off latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_stop_time  <= '0;
            r_gate       <= 1'b0;
        end else if (in_xfer) begin
            if (i_in_data.action == adsr_pkg::ACT_NOTE_ON) begin
                r_start_time <= i_in_data.sample_time;
                r_gate       <= 1'b1;
            end else if (i_in_data.action == adsr_pkg::ACT_NOTE_OFF) begin
                r_stop_time <= i_in_data.sample_time;
                r_gate      <= 1'b0;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_DIFF;
            S_DIFF: n_state = S_SEL;
            S_SEL:  n_state = (sel_mode == M_DIRECT) ? S_FIN : S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (div_stat.done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Phase selection from elapsed time
    always_comb begin
        decay_pos  = r_elapsed - TB'(r_attack);
        sel_mode   = M_DIRECT;
        sel_phase  = adsr_pkg::PH_RELEASE;
        sel_base   = '0;
        sel_a      = r_hold;
        sel_b      = r_release - r_elapsed[DB-1:0];
        sel_den    = r_release;
        if (r_gate) begin
            if (r_attack != '0 && r_elapsed <= TB'(r_attack)) begin
                sel_mode   = M_QUOT;
                sel_phase  = adsr_pkg::PH_ATTACK;
                sel_a      = r_peak;
                sel_b      = r_elapsed[DB-1:0];
                sel_den    = r_attack;
            end else if (r_decay != '0 && decay_pos <= TB'(r_decay)) begin
                sel_phase = adsr_pkg::PH_DECAY;
                sel_base  = r_peak;
                sel_b     = decay_pos[DB-1:0];
                sel_den   = r_decay;
                if (r_hold >= r_peak) begin
                    sel_mode   = M_ADD;
                    sel_a      = r_hold - r_peak;
                end else begin
                    sel_mode   = M_SUB;
                    sel_a      = r_peak - r_hold;
                end
            end else begin
                sel_phase = adsr_pkg::PH_SUSTAIN;
                sel_base  = r_hold;
            end
        end else if (r_release != '0 && r_elapsed < TB'(r_release)) begin
            sel_mode = M_QUOT;
        end
    end

    // Final level with epsilon floor
    logic [LB-1:0] fin_level;
    always_comb begin
        unique case (r_mode)
            M_DIRECT: fin_level = r_base;
            M_QUOT:   fin_level = div_quot;
            M_ADD:    fin_level = r_base + div_quot;
            M_SUB:    fin_level = r_base - div_quot;
            default:  fin_level = r_base;
        endcase
        if (fin_level < adsr_pkg::EPS_LIMIT) begin
            fin_level = '0;
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_MUL);
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: r_now <= i_in_data.sample_time;
            S_DIFF: r_elapsed <= r_now - (r_gate ? r_start_time : r_stop_time);
            S_SEL: begin
                r_mode  <= sel_mode;
                r_phase <= sel_phase;
                r_base  <= sel_base;
                r_mul_a <= sel_a;
                r_mul_b <= sel_b;
                r_den   <= sel_den;
            end
            S_MUL: r_prod <= PB'(r_mul_a) * PB'(r_mul_b);
            S_DIV: ;
            S_FIN: begin
                if (out_free) begin
                    r_out.level <= fin_level;
                    r_out.phase <= r_phase;
                end
            end
            default: ;
        endcase
    end

    adsr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !div_stat.busy)
        else $error("divider started while busy");

    a_accept_to_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_DIFF)
        else $error("transfer did not start the sequencer");

    a_done_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_stat.done) |=> r_state == S_FIN)
        else $error("divide result not consumed");

    a_eps_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.level != '0) |-> r_out.level >= adsr_pkg::EPS_LIMIT)
        else $error("level below epsilon delivered");

endmodule

`default_nettype wire
